// ===== src/cbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Console bus decoder package
// Item types, opcode and route codes, address map constants and the
// controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package cbd_pkg;

   localparam int ADDR_W    = 16;
   localparam int RECIP_W   = 17;
   localparam int EXP_BYTES = 8160;
   localparam int EXP_AW    = 13;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [2:0] ROUTE_RAM  = 3'd0;
   localparam logic [2:0] ROUTE_PPU  = 3'd1;
   localparam logic [2:0] ROUTE_IO   = 3'd2;
   localparam logic [2:0] ROUTE_EXP  = 3'd3;
   localparam logic [2:0] ROUTE_SRAM = 3'd4;
   localparam logic [2:0] ROUTE_CART = 3'd5;
   localparam logic [2:0] ROUTE_NONE = 3'd6;

   localparam logic [15:0] PPU_BASE  = 16'h2000;
   localparam logic [15:0] IO_BASE   = 16'h4000;
   localparam logic [15:0] EXP_BASE  = 16'h4020;
   localparam logic [15:0] SRAM_BASE = 16'h6000;
   localparam logic [15:0] CART_BASE = 16'h8000;
   localparam logic [15:0] DMA_ADDR  = 16'h4014;
   localparam logic [15:0] PAD0_ADDR = 16'h4016;
   localparam logic [15:0] PAD1_ADDR = 16'h4017;
   localparam logic [15:0] EXP_SIZE  = 16'h1FE0;
   localparam logic [15:0] EXP_FOLD  = 16'h3FC0; // two expansion spans

   localparam logic [2:0] PHASE_ODD_SLOT = 3'd3;
   localparam logic [2:0] PHASE_LAST     = 3'd5;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [7:0]  ext_read_data;
      logic [7:0]  pad0_buttons;
      logic [7:0]  pad1_buttons;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  route;
      logic [15:0] bus_address;
      logic [7:0]  data_out;
      logic [7:0]  oam_index;
      logic        oam_write;
      logic        cpu_enable;
      logic        dma_busy;
   } rsp_item_type;

   typedef struct packed {
      logic clear_en;
      logic load_item;
      logic decode_en;
      logic look_en;
      logic commit_en;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } status_type;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_DECODE = 5'b00100,
      ST_LOOK   = 5'b01000,
      ST_COMMIT = 5'b10000
   } state_type;

   function automatic logic [2:0] region_of(input logic [15:0] a);
      logic [2:0] r;
      if (a < PPU_BASE) begin
         r = ROUTE_RAM;
      end else if (a < IO_BASE) begin
         r = ROUTE_PPU;
      end else if (a < EXP_BASE) begin
         r = ROUTE_IO;
      end else if (a < SRAM_BASE) begin
         r = ROUTE_EXP;
      end else if (a < CART_BASE) begin
         r = ROUTE_SRAM;
      end else begin
         r = ROUTE_CART;
      end
      return r;
   endfunction

endpackage

// ===== src/cbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Console bus decoder controller
// Sequences the clearing pass and the decode / lookup / commit steps of each
// item, and owns the result valid flag.
// ----------------------------------------------------------------------------
module cbd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  cbd_pkg::status_type status,
   output cbd_pkg::cmd_type    cmd
);
   import cbd_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      commit_fire;

   // commit only when the output register is free or being emptied
   assign commit_fire = (state_ff == ST_COMMIT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit_fire) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign rsp_valid_in = commit_fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign cmd.clear_en  = (state_ff == ST_CLEAR);
   assign cmd.load_item = (state_ff == ST_IDLE) && req_valid;
   assign cmd.decode_en = (state_ff == ST_DECODE);
   assign cmd.look_en   = (state_ff == ST_LOOK);
   assign cmd.commit_en = commit_fire;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/cbd_datapath.sv =====
// ----------------------------------------------------------------------------
// Console bus decoder datapath
// Item register, address folding, the three byte memories, I/O registers,
// sprite DMA state and the result register.
// ----------------------------------------------------------------------------
module cbd_datapath #(
   parameter int RAM_BYTES      = 2048,
   parameter int IO_REG_COUNT   = 32,
   parameter int SAVE_RAM_BYTES = 8192
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cbd_pkg::cmd_type      cmd,
   output cbd_pkg::status_type   status,
   input  cbd_pkg::req_item_type req_item,
   output cbd_pkg::rsp_item_type rsp_item
);
   import cbd_pkg::*;

   localparam int RAM_AW  = $clog2(RAM_BYTES);
   localparam int SRAM_AW = $clog2(SAVE_RAM_BYTES);
   localparam int IO_AW   = $clog2(IO_REG_COUNT);
   localparam int PROD_W  = ADDR_W + RECIP_W;

   // exact reciprocals for 16-bit dividends
   localparam int RAM_S  = ADDR_W + RAM_AW;
   localparam int SRAM_S = ADDR_W + SRAM_AW;
   localparam logic [63:0] RAM_M =
      ((64'd1 << RAM_S) + 64'(RAM_BYTES) - 64'd1) / 64'(RAM_BYTES);
   localparam logic [63:0] SRAM_M =
      ((64'd1 << SRAM_S) + 64'(SAVE_RAM_BYTES) - 64'd1) / 64'(SAVE_RAM_BYTES);

   localparam int CLR_LEN_A = (RAM_BYTES > EXP_BYTES) ? RAM_BYTES : EXP_BYTES;
   localparam int CLR_LEN   = (CLR_LEN_A > SAVE_RAM_BYTES) ? CLR_LEN_A : SAVE_RAM_BYTES;
   localparam int CLR_W     = $clog2(CLR_LEN);

   // ---------------- item and clear counter
   req_item_type item_ff;
   logic [CLR_W-1:0] clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_item) item_ff <= req_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_en) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   assign status.clear_last = (32'(clr_cnt_ff) == CLR_LEN - 1);

   // ---------------- DMA state
   logic [2:0] phase_ff, phase_in;
   logic       active_ff, active_in;
   logic       waiting_ff, waiting_in;
   logic [7:0] page_ff, page_in;
   logic [7:0] offset_ff, offset_in;
   logic [7:0] latch_ff, latch_in;

   // ---------------- decode step: effective address and quotients
   logic [15:0]       eff_in, eff_addr_ff;
   logic [PROD_W-1:0] ram_prod, sram_prod;
   logic [15:0]       ram_q_ff, sram_q_ff;

   assign eff_in    = (item_ff.opcode == OP_TICK) ? {page_ff, offset_ff} : item_ff.address;
   assign ram_prod  = PROD_W'(eff_in) * PROD_W'(RAM_M[RECIP_W-1:0]);
   assign sram_prod = PROD_W'(eff_in) * PROD_W'(SRAM_M[RECIP_W-1:0]);

   always_ff @(posedge clock) begin
      if (cmd.decode_en) begin
         eff_addr_ff <= eff_in;
         ram_q_ff    <= ADDR_W'(ram_prod >> RAM_S);
         sram_q_ff   <= ADDR_W'(sram_prod >> SRAM_S);
      end
   end

   // ---------------- lookup step: remainders and memory reads
   logic [31:0]        ram_rem, sram_rem;
   logic [15:0]        exp_t;
   logic [EXP_AW-1:0]  exp_idx, exp_idx_ff;
   logic [RAM_AW-1:0]  ram_idx_ff;
   logic [SRAM_AW-1:0] sram_idx_ff;

   assign ram_rem  = 32'(eff_addr_ff) - 32'(ram_q_ff) * 32'(RAM_BYTES);
   assign sram_rem = 32'(eff_addr_ff) - 32'(sram_q_ff) * 32'(SAVE_RAM_BYTES);
   assign exp_t    = eff_addr_ff - EXP_FOLD;
   assign exp_idx  = (exp_t >= EXP_SIZE) ? EXP_AW'(exp_t - EXP_SIZE) : EXP_AW'(exp_t);

   always_ff @(posedge clock) begin
      if (cmd.look_en) begin
         ram_idx_ff  <= ram_rem[RAM_AW-1:0];
         sram_idx_ff <= sram_rem[SRAM_AW-1:0];
         exp_idx_ff  <= exp_idx;
      end
   end

   // ---------------- memories (cleared by a sweep after reset)
   logic [7:0] work_ram [RAM_BYTES];
   logic [7:0] expansion_store [EXP_BYTES];
   logic [7:0] save_ram [SAVE_RAM_BYTES];
   logic [7:0] ram_rd_ff, exp_rd_ff, sram_rd_ff;

   logic               ram_we, exp_we, sram_we;
   logic [RAM_AW-1:0]  ram_wa;
   logic [EXP_AW-1:0]  exp_wa;
   logic [SRAM_AW-1:0] sram_wa;
   logic [7:0]         mem_wd;
   logic               wr_ram, wr_exp, wr_sram;

   assign ram_we  = (cmd.clear_en && (32'(clr_cnt_ff) < RAM_BYTES)) ||
                    (cmd.commit_en && wr_ram);
   assign exp_we  = (cmd.clear_en && (32'(clr_cnt_ff) < EXP_BYTES)) ||
                    (cmd.commit_en && wr_exp);
   assign sram_we = (cmd.clear_en && (32'(clr_cnt_ff) < SAVE_RAM_BYTES)) ||
                    (cmd.commit_en && wr_sram);
   assign ram_wa  = cmd.clear_en ? clr_cnt_ff[RAM_AW-1:0]  : ram_idx_ff;
   assign exp_wa  = cmd.clear_en ? clr_cnt_ff[EXP_AW-1:0]  : exp_idx_ff;
   assign sram_wa = cmd.clear_en ? clr_cnt_ff[SRAM_AW-1:0] : sram_idx_ff;
   assign mem_wd  = cmd.clear_en ? 8'd0 : item_ff.write_data;

   always_ff @(posedge clock) begin
      if (ram_we) work_ram[ram_wa] <= mem_wd;
      if (cmd.look_en) ram_rd_ff <= work_ram[ram_rem[RAM_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (exp_we) expansion_store[exp_wa] <= mem_wd;
      if (cmd.look_en) exp_rd_ff <= expansion_store[exp_idx];
   end

   always_ff @(posedge clock) begin
      if (sram_we) save_ram[sram_wa] <= mem_wd;
      if (cmd.look_en) sram_rd_ff <= save_ram[sram_rem[SRAM_AW-1:0]];
   end

   // ---------------- commit step
   logic [7:0]  io_regs_ff [IO_REG_COUNT];
   logic [IO_AW-1:0] io_idx;
   logic [7:0]  io_val, rd_val, io_wd;
   logic        io_we;
   logic [2:0]  region;
   logic        pad_hit, slot, odd;
   rsp_item_type rsp_in, rsp_ff;

   assign region  = region_of(eff_addr_ff);
   assign io_idx  = IO_AW'(eff_addr_ff[4:0]);
   assign io_val  = io_regs_ff[io_idx];
   assign pad_hit = (eff_addr_ff == PAD0_ADDR) || (eff_addr_ff == PAD1_ADDR);
   assign slot    = (phase_ff == 3'd0) || (phase_ff == PHASE_ODD_SLOT);
   assign odd     = phase_ff[0];

   always_comb begin
      case (region)
         ROUTE_RAM:  rd_val = ram_rd_ff;
         ROUTE_IO:   rd_val = pad_hit ? {7'd0, io_val[7]} : io_val;
         ROUTE_EXP:  rd_val = exp_rd_ff;
         ROUTE_SRAM: rd_val = sram_rd_ff;
         default:    rd_val = item_ff.ext_read_data;
      endcase
   end

   always_comb begin
      rsp_in       = '0;
      rsp_in.route = ROUTE_NONE;
      phase_in     = phase_ff;
      active_in    = active_ff;
      waiting_in   = waiting_ff;
      page_in      = page_ff;
      offset_in    = offset_ff;
      latch_in     = latch_ff;
      io_we        = 1'b0;
      io_wd        = {io_val[6:0], 1'b0};   // pad read shift
      wr_ram       = 1'b0;
      wr_exp       = 1'b0;
      wr_sram      = 1'b0;
      case (item_ff.opcode)
         OP_READ: begin
            rsp_in.route       = region;
            rsp_in.bus_address = eff_addr_ff;
            rsp_in.data_out    = rd_val;
            io_we              = (region == ROUTE_IO) && pad_hit;
         end
         OP_WRITE: begin
            rsp_in.route       = region;
            rsp_in.bus_address = eff_addr_ff;
            rsp_in.data_out    = item_ff.write_data;
            wr_ram             = (region == ROUTE_RAM);
            wr_exp             = (region == ROUTE_EXP);
            wr_sram            = (region == ROUTE_SRAM);
            if (region == ROUTE_IO) begin
               if (eff_addr_ff == DMA_ADDR) begin
                  page_in   = item_ff.write_data;
                  offset_in = 8'd0;
                  active_in = 1'b1;
               end else begin
                  io_we = 1'b1;
                  if (pad_hit) begin
                     io_wd = eff_addr_ff[0] ? item_ff.pad1_buttons : item_ff.pad0_buttons;
                  end else begin
                     io_wd = item_ff.write_data;
                  end
               end
            end
         end
         OP_TICK: begin
            phase_in = (phase_ff == PHASE_LAST) ? 3'd0 : phase_ff + 3'd1;
            if (slot) begin
               if (!active_ff) begin
                  rsp_in.cpu_enable = 1'b1;
               end else if (waiting_ff) begin
                  if (odd) waiting_in = 1'b0;
               end else if (!odd) begin
                  // DMA read: an ordinary read with its side effects
                  rsp_in.route       = region;
                  rsp_in.bus_address = eff_addr_ff;
                  rsp_in.data_out    = rd_val;
                  latch_in           = rd_val;
                  io_we              = (region == ROUTE_IO) && pad_hit;
               end else begin
                  rsp_in.oam_index = offset_ff;
                  rsp_in.oam_write = 1'b1;
                  rsp_in.data_out  = latch_ff;
                  offset_in        = offset_ff + 8'd1;
                  if (offset_ff == 8'hFF) begin
                     active_in  = 1'b0;
                     waiting_in = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      rsp_in.dma_busy = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < IO_REG_COUNT; i++) io_regs_ff[i] <= 8'd0;
      end else if (cmd.commit_en && io_we) begin
         io_regs_ff[io_idx] <= io_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= 3'd0;
         active_ff  <= 1'b0;
         waiting_ff <= 1'b1;
         page_ff    <= 8'd0;
         offset_ff  <= 8'd0;
         latch_ff   <= 8'd0;
      end else if (cmd.commit_en) begin
         phase_ff   <= phase_in;
         active_ff  <= active_in;
         waiting_ff <= waiting_in;
         page_ff    <= page_in;
         offset_ff  <= offset_in;
         latch_ff   <= latch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit_en) rsp_ff <= rsp_in;
   end

   assign rsp_item = rsp_ff;

endmodule

// ===== src/console_bus_decoder_with_sprite_dma.sv =====
// Sequencing: an accepted item passes the decode, lookup and commit steps before its
//   result is in the output register; the commit waits while the previous result is unread.
// No new item is taken until that commit; the byte memories are read through a register
//   and the reciprocal multiply that folds the address into RAM indexes is registered.
// Reset: synchronous; a clearing sweep over max(RAM_BYTES, 8160, SAVE_RAM_BYTES)
//   addresses (8192 at defaults) zeroes the memories before the first item is taken.
// ----------------------------------------------------------------------------
// Console bus decoder with sprite DMA
// Decodes CPU reads, writes and clock ticks onto work RAM, I/O registers,
// expansion store, save RAM and external regions; runs the 256-byte OAM DMA.
// ----------------------------------------------------------------------------
module console_bus_decoder_with_sprite_dma #(
   parameter int RAM_BYTES      = 2048,
   parameter int IO_REG_COUNT   = 32,
   parameter int SAVE_RAM_BYTES = 8192
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cbd_pkg::req_item_type req_item,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cbd_pkg::rsp_item_type rsp_item
);
   import cbd_pkg::*;

   // Control and status between the sequencer and the datapath.
   cmd_type    cmd;
   status_type status;

   // Sequencer: clear sweep, then idle -> decode -> lookup -> commit per item.
   // The commit waits only while an older result still sits unread.
   cbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: address folding, memories, pad latches, DMA state and the
   // result register that decouples the two channels.
   cbd_datapath #(
      .RAM_BYTES      (RAM_BYTES),
      .IO_REG_COUNT   (IO_REG_COUNT),
      .SAVE_RAM_BYTES (SAVE_RAM_BYTES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

   // one item in flight: nothing new is taken right after an accept
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while another is in flight");

   // no item may enter while the memories are being cleared
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_en |-> req_stall)
      else $error("request taken during clear sweep");

   // a new result only appears after a commit
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.commit_en))
      else $error("result valid without commit");

   // an OAM write tick never routes onto the bus
   a_oam_no_route: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.oam_write) |-> (rsp_item.route == ROUTE_NONE))
      else $error("OAM write with bus route");

endmodule
